// File: rtl/core/mip_pkg.sv
// shared constants, types and record builders for the meshlet index packer
`timescale 1ns / 1ps

package mip_pkg;

  localparam int MAX_VERTS  = 64;
  localparam int LIDX_W     = $clog2(MAX_VERTS);
  localparam int VCNT_W     = $clog2(MAX_VERTS + 1);
  localparam int VAL_W      = 32;
  localparam int PRIM_W     = 8;
  localparam int VLIM_W     = 7;
  localparam int KIND_W     = 2;
  localparam int MAX_RECS   = 6;
  localparam int REC_IDX_W  = $clog2(MAX_RECS + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [VLIM_W-1:0] VLIM_RESET = VLIM_W'(64);
  localparam logic [PRIM_W-1:0] PLIM_RESET = PRIM_W'(126);

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMITIVE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_MESHLET  = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } mip_state_t;

  typedef struct packed {
    rec_kind_t               kind;
    logic [VAL_W-1:0]        vertex_value;
    logic [LIDX_W-1:0]       local_a;
    logic [LIDX_W-1:0]       local_b;
    logic [LIDX_W-1:0]       local_c;
    logic [PRIM_W-1:0]       prims;
    logic [VCNT_W-1:0]       verts;
    logic [VAL_W-1:0]        unique_offset;
    logic [VAL_W-1:0]        packed_offset;
  } rec_t;

  // meshlet state seen by the merge stage
  typedef struct packed {
    logic                    close;
    logic                    final_tri;
    logic [VCNT_W-1:0]       vert_count;
    logic [PRIM_W-1:0]       prim_count;
    logic [VAL_W-1:0]        unique_base;
    logic [VAL_W-1:0]        packed_base;
    logic [VAL_W-1:0]        unique_total;
    logic [VAL_W-1:0]        packed_total;
  } mip_ctx_t;

  // merge stage results: records plus next meshlet state
  typedef struct packed {
    rec_t [MAX_RECS-1:0]     recs;
    logic [REC_IDX_W-1:0]    rec_cnt;
    logic [2:0]              append;
    logic [LIDX_W-1:0]       local_a;
    logic [LIDX_W-1:0]       local_b;
    logic [LIDX_W-1:0]       local_c;
    logic [VCNT_W-1:0]       vert_count;
    logic [PRIM_W-1:0]       prim_count;
    logic [VAL_W-1:0]        unique_base;
    logic [VAL_W-1:0]        packed_base;
    logic [VAL_W-1:0]        unique_total;
    logic [VAL_W-1:0]        packed_total;
  } mip_merge_t;

  function automatic logic [LIDX_W-1:0] first_set(input logic [MAX_VERTS-1:0] m);
    logic [LIDX_W-1:0] pos;
    pos = '0;
    for (int k = MAX_VERTS - 1; k >= 0; k--) begin
      if (m[k]) begin
        pos = LIDX_W'(k);
      end
    end
    return pos;
  endfunction

  function automatic rec_t mk_vertex(input logic [VAL_W-1:0] value);
    rec_t r;
    r              = '0;
    r.kind         = KIND_VERTEX;
    r.vertex_value = value;
    return r;
  endfunction

  function automatic rec_t mk_triangle(input logic [LIDX_W-1:0] la,
                                       input logic [LIDX_W-1:0] lb,
                                       input logic [LIDX_W-1:0] lc);
    rec_t r;
    r         = '0;
    r.kind    = KIND_TRIANGLE;
    r.local_a = la;
    r.local_b = lb;
    r.local_c = lc;
    return r;
  endfunction

  function automatic rec_t mk_meshlet(input logic [PRIM_W-1:0] prims,
                                      input logic [VCNT_W-1:0] verts,
                                      input logic [VAL_W-1:0]  uoff,
                                      input logic [VAL_W-1:0]  poff);
    rec_t r;
    r               = '0;
    r.kind          = KIND_MESHLET;
    r.prims         = prims;
    r.verts         = verts;
    r.unique_offset = uoff;
    r.packed_offset = poff;
    return r;
  endfunction

endpackage

// File: rtl/core/mip_ifs.sv
// triangle input and result output channel interfaces
`timescale 1ns / 1ps

interface mip_in_if
  import mip_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] index_a;
  logic [VAL_W-1:0] index_b;
  logic [VAL_W-1:0] index_c;
  logic             final_triangle;

  modport source(output valid, output index_a, output index_b, output index_c,
                 output final_triangle, input ready);
  modport sink(input valid, input index_a, input index_b, input index_c,
               input final_triangle, output ready);
endinterface

interface mip_out_if
  import mip_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] rec_kind;
  logic [VAL_W-1:0]  vertex_value;
  logic [LIDX_W-1:0] local_a;
  logic [LIDX_W-1:0] local_b;
  logic [LIDX_W-1:0] local_c;
  logic [PRIM_W-1:0] meshlet_prims;
  logic [VCNT_W-1:0] meshlet_verts;
  logic [VAL_W-1:0]  meshlet_unique_offset;
  logic [VAL_W-1:0]  meshlet_packed_offset;
  logic              last_of_run;

  modport source(output valid, output rec_kind, output vertex_value, output local_a,
                 output local_b, output local_c, output meshlet_prims,
                 output meshlet_verts, output meshlet_unique_offset,
                 output meshlet_packed_offset, output last_of_run, input ready);
  modport sink(input valid, input rec_kind, input vertex_value, input local_a,
               input local_b, input local_c, input meshlet_prims,
               input meshlet_verts, input meshlet_unique_offset,
               input meshlet_packed_offset, input last_of_run, output ready);
endinterface

// File: rtl/core/mip_lane.sv
// one lookup lane: compares a vertex index against every live list entry
`timescale 1ns / 1ps

module mip_lane
  import mip_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [VAL_W-1:0]     key,
  input  logic [VAL_W-1:0]     list [MAX_VERTS],
  input  logic [MAX_VERTS-1:0] live,
  output logic [MAX_VERTS-1:0] match_r
);

  logic [MAX_VERTS-1:0] match_nxt;

  always_comb begin
    for (int k = 0; k < MAX_VERTS; k++) begin
      match_nxt[k] = live[k] && (list[k] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      match_r <= match_nxt;
    end
  end

endmodule

// File: rtl/core/mip_merge.sv
// merge stage: resolves local indices from the lane hits and builds the records
`timescale 1ns / 1ps

module mip_merge
  import mip_pkg::*;
(
  input  mip_ctx_t             ctx,
  input  logic [VAL_W-1:0]     index_a,
  input  logic [VAL_W-1:0]     index_b,
  input  logic [VAL_W-1:0]     index_c,
  input  logic [MAX_VERTS-1:0] match_a,
  input  logic [MAX_VERTS-1:0] match_b,
  input  logic [MAX_VERTS-1:0] match_c,
  output mip_merge_t           res
);

  logic [VCNT_W-1:0]    cnt0, cnt1, cnt2, cnt3;
  logic [PRIM_W-1:0]    prim0, prim1;
  logic [VAL_W-1:0]     ubase0, pbase0, utotal1, ptotal1;
  logic                 new_a, new_b, new_c;
  logic [LIDX_W-1:0]    la, lb, lc;
  logic [REC_IDX_W-1:0] n;
  rec_t [MAX_RECS-1:0]  recs;

  always_comb begin
    cnt0   = ctx.close ? '0 : ctx.vert_count;
    prim0  = ctx.close ? '0 : ctx.prim_count;
    ubase0 = ctx.close ? ctx.unique_total : ctx.unique_base;
    pbase0 = ctx.close ? ctx.packed_total : ctx.packed_base;
    prim1  = prim0 + PRIM_W'(1);

    // first vertex
    new_a = ~|match_a;
    la    = new_a ? cnt0[LIDX_W-1:0] : first_set(match_a);
    cnt1  = cnt0 + VCNT_W'(new_a);

    // second vertex, may repeat the first
    new_b = 1'b0;
    if (|match_b) begin
      lb = first_set(match_b);
    end else if (index_b == index_a) begin
      lb = la;
    end else begin
      lb    = cnt1[LIDX_W-1:0];
      new_b = 1'b1;
    end
    cnt2 = cnt1 + VCNT_W'(new_b);

    // third vertex, may repeat either earlier one
    new_c = 1'b0;
    if (|match_c) begin
      lc = first_set(match_c);
    end else if (index_c == index_a) begin
      lc = la;
    end else if (index_c == index_b) begin
      lc = lb;
    end else begin
      lc    = cnt2[LIDX_W-1:0];
      new_c = 1'b1;
    end
    cnt3 = cnt2 + VCNT_W'(new_c);

    utotal1 = ctx.unique_total + VAL_W'(new_a) + VAL_W'(new_b) + VAL_W'(new_c);
    ptotal1 = ctx.packed_total + VAL_W'(3);

    recs = '0;
    n    = '0;
    if (ctx.close) begin
      recs[n] = mk_meshlet(ctx.prim_count, ctx.vert_count, ctx.unique_base,
                           ctx.packed_base);
      n = n + REC_IDX_W'(1);
    end
    if (new_a) begin
      recs[n] = mk_vertex(index_a);
      n = n + REC_IDX_W'(1);
    end
    if (new_b) begin
      recs[n] = mk_vertex(index_b);
      n = n + REC_IDX_W'(1);
    end
    if (new_c) begin
      recs[n] = mk_vertex(index_c);
      n = n + REC_IDX_W'(1);
    end
    recs[n] = mk_triangle(la, lb, lc);
    n = n + REC_IDX_W'(1);
    if (ctx.final_tri) begin
      recs[n] = mk_meshlet(prim1, cnt3, ubase0, pbase0);
      n = n + REC_IDX_W'(1);
    end

    res.recs         = recs;
    res.rec_cnt      = n;
    res.append       = {new_c, new_b, new_a};
    res.local_a      = la;
    res.local_b      = lb;
    res.local_c      = lc;
    res.unique_total = utotal1;
    res.packed_total = ptotal1;
    if (ctx.final_tri) begin
      res.vert_count  = '0;
      res.prim_count  = '0;
      res.unique_base = utotal1;
      res.packed_base = ptotal1;
    end else begin
      res.vert_count  = cnt3;
      res.prim_count  = prim1;
      res.unique_base = ubase0;
      res.packed_base = pbase0;
    end
  end

endmodule

// File: rtl/core/meshlet_index_packer_core.sv
// top level of the meshlet index packer: list storage, lookup lanes and record sequencer
//
// in_chan takes one triangle word (three global vertex indices and a final
// flag). out_chan gives result words in order: a meshlet descriptor when the
// triangle does not fit, one word per new unique vertex, the packed triangle,
// and a descriptor after a final triangle. last_of_run marks the last word of
// each triangle. cfg_we/cfg_index/cfg_data set the vertex and primitive
// limits; write them only while no triangle is in flight.
// Timing: the accept edge runs three compare lanes against the whole unique
// list, the next cycle merges their hits and updates the meshlet state, and
// the first result word is valid in the cycle after that. A triangle gives
// n result words (1 to 6); the next triangle is accepted on the edge that
// takes the last word of the current one.
// A stalled receiver holds the current word and the block takes no triangle.
// Reset restores limits 64 and 126 and zeroes counts and running totals; the
// list contents need no clearing, so the block is ready right after reset.
`timescale 1ns / 1ps

module meshlet_index_packer_core
  import mip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mip_in_if.sink                in_chan,
  mip_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mip_state_t           state_r, state_nxt;
  logic [VLIM_W-1:0]    vlim_r;
  logic [PRIM_W-1:0]    plim_r;
  logic [VAL_W-1:0]     list_r [MAX_VERTS];
  logic [VCNT_W-1:0]    vert_count_r;
  logic [PRIM_W-1:0]    prim_count_r;
  logic [VAL_W-1:0]     unique_base_r, packed_base_r, unique_total_r, packed_total_r;
  logic [VAL_W-1:0]     idx_a_r, idx_b_r, idx_c_r;
  logic                 final_r, close_r;
  rec_t [MAX_RECS-1:0]  recs_r;
  logic [REC_IDX_W-1:0] rec_cnt_r, ptr_r;

  logic                 in_ready, out_valid, accept, commit, out_take, last_word;
  logic                 close_now;
  logic [VLIM_W-1:0]    vlim_eff;
  logic [VCNT_W-1:0]    live_cnt;
  logic [MAX_VERTS-1:0] live;
  logic [MAX_VERTS-1:0] match_a, match_b, match_c;
  mip_ctx_t             ctx;
  mip_merge_t           mres;
  rec_t                 cur;

  // close test for the incoming triangle
  assign vlim_eff  = (vlim_r > VLIM_W'(MAX_VERTS)) ? VLIM_W'(MAX_VERTS) : vlim_r;
  assign close_now = (({1'b0, prim_count_r} + (PRIM_W + 1)'(1)) > {1'b0, plim_r}) ||
                     (({1'b0, vert_count_r} + (VCNT_W + 1)'(3)) >
                      (VCNT_W + 1)'(vlim_eff));
  assign live_cnt  = close_now ? '0 : vert_count_r;

  for (genvar k = 0; k < MAX_VERTS; k++) begin : g_live
    assign live[k] = VCNT_W'(k) < live_cnt;
  end

  mip_lane u_lane_a (
    .clk(clk), .en(accept), .key(in_chan.index_a), .list(list_r), .live(live),
    .match_r(match_a)
  );
  mip_lane u_lane_b (
    .clk(clk), .en(accept), .key(in_chan.index_b), .list(list_r), .live(live),
    .match_r(match_b)
  );
  mip_lane u_lane_c (
    .clk(clk), .en(accept), .key(in_chan.index_c), .list(list_r), .live(live),
    .match_r(match_c)
  );

  always_comb begin
    ctx.close        = close_r;
    ctx.final_tri    = final_r;
    ctx.vert_count   = vert_count_r;
    ctx.prim_count   = prim_count_r;
    ctx.unique_base  = unique_base_r;
    ctx.packed_base  = packed_base_r;
    ctx.unique_total = unique_total_r;
    ctx.packed_total = packed_total_r;
  end

  mip_merge u_merge (
    .ctx(ctx), .index_a(idx_a_r), .index_b(idx_b_r), .index_c(idx_c_r),
    .match_a(match_a), .match_b(match_b), .match_c(match_c), .res(mres)
  );

  // sequencer
  assign last_word = (ptr_r == (rec_cnt_r - REC_IDX_W'(1)));
  assign out_take  = out_valid && out_chan.ready;
  assign accept    = in_ready && in_chan.valid;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        commit    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_chan.ready && last_word) begin
          in_ready  = 1'b1;
          state_nxt = in_chan.valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r <= VLIM_RESET;
      plim_r <= PLIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_LIMIT:    vlim_r <= cfg_data[VLIM_W-1:0];
        CFG_PRIMITIVE_LIMIT: plim_r <= cfg_data[PRIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // meshlet state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_count_r   <= '0;
      prim_count_r   <= '0;
      unique_base_r  <= '0;
      packed_base_r  <= '0;
      unique_total_r <= '0;
      packed_total_r <= '0;
    end else if (commit) begin
      vert_count_r   <= mres.vert_count;
      prim_count_r   <= mres.prim_count;
      unique_base_r  <= mres.unique_base;
      packed_base_r  <= mres.packed_base;
      unique_total_r <= mres.unique_total;
      packed_total_r <= mres.packed_total;
    end
  end

  // unique list appends
  always_ff @(posedge clk) begin
    if (commit) begin
      for (int k = 0; k < MAX_VERTS; k++) begin
        if (mres.append[0] && (mres.local_a == LIDX_W'(k))) begin
          list_r[k] <= idx_a_r;
        end
        if (mres.append[1] && (mres.local_b == LIDX_W'(k))) begin
          list_r[k] <= idx_b_r;
        end
        if (mres.append[2] && (mres.local_c == LIDX_W'(k))) begin
          list_r[k] <= idx_c_r;
        end
      end
    end
  end

  // triangle word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_a_r <= in_chan.index_a;
      idx_b_r <= in_chan.index_b;
      idx_c_r <= in_chan.index_c;
      final_r <= in_chan.final_triangle;
      close_r <= close_now;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (commit) begin
      recs_r    <= mres.recs;
      rec_cnt_r <= mres.rec_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (commit) begin
      ptr_r <= '0;
    end else if (out_take && !last_word) begin
      ptr_r <= ptr_r + REC_IDX_W'(1);
    end
  end

  assign cur = recs_r[ptr_r];

  assign in_chan.ready                  = in_ready;
  assign out_chan.valid                 = out_valid;
  assign out_chan.rec_kind              = cur.kind;
  assign out_chan.vertex_value          = cur.vertex_value;
  assign out_chan.local_a               = cur.local_a;
  assign out_chan.local_b               = cur.local_b;
  assign out_chan.local_c               = cur.local_c;
  assign out_chan.meshlet_prims         = cur.prims;
  assign out_chan.meshlet_verts         = cur.verts;
  assign out_chan.meshlet_unique_offset = cur.unique_offset;
  assign out_chan.meshlet_packed_offset = cur.packed_offset;
  assign out_chan.last_of_run           = last_word;

endmodule
